// ===== src/zcpf_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the zero cross peak frequency meter
package zcpf_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int TIME_W      = 32;
	localparam int FREQ_W      = 19;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(500000);
	localparam logic [FREQ_W-1:0] HALF_MEGA = FREQ_W'(500000);
	localparam int DIV_CNT_W = $clog2(FREQ_W + 1);

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = CFG_IDX_W'(1);

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_START  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WAIT  = 2'd1,
		PH_BELOW = 2'd2,
		PH_ABOVE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		DV_IDLE = 2'd0,
		DV_RUN  = 2'd1,
		DV_DONE = 2'd2
	} div_state_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level_mv;
		logic [TIME_W-1:0]          half_period_us;
	} job_t;

	typedef struct packed {
		logic push;
	} queue_ctl_t;

endpackage

// ===== src/zcpf_if.sv =====
`timescale 1ns / 1ps
// channel interfaces for samples, results and configuration writes
interface zcpf_smp_if;
	import zcpf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic signed [SAMPLE_W-1:0] sample_mv;
	logic [TIME_W-1:0]          time_us;
	modport source (output valid, func, sample_mv, time_us, input ready);
	modport sink (input valid, func, sample_mv, time_us, output ready);
endinterface

interface zcpf_res_if;
	import zcpf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] level_mv;
	logic [TIME_W-1:0]          half_period_us;
	logic [FREQ_W-1:0]          freq_hz;
	modport source (output valid, level_mv, half_period_us, freq_hz, input ready);
	modport sink (input valid, level_mv, half_period_us, freq_hz, output ready);
endinterface

interface zcpf_cfg_if;
	import zcpf_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/zcpf_front.sv =====
`timescale 1ns / 1ps
// front end: configuration registers, phase machine and peak tracking
module zcpf_front (
	input  logic                clk,
	input  logic                arst_n,
	zcpf_smp_if.sink            smp,
	zcpf_cfg_if.sink            cfg,
	input  logic                q_full,
	output zcpf_pkg::queue_ctl_t q_ctl,
	output zcpf_pkg::job_t      job
);
	import zcpf_pkg::*;

	logic signed [SAMPLE_W-1:0] margin_q;
	logic signed [SAMPLE_W-1:0] offset_q;
	logic signed [SAMPLE_W-1:0] peak_q;
	logic [TIME_W-1:0]          start_q;
	phase_t                     phase_q;
	phase_t                     phase_d;
	logic                       acc;
	logic                       is_zero;
	logic                       track;
	logic                       load_start;
	logic signed [SAMPLE_W:0]   sum;

	assign cfg.ready = 1'b1;
	assign smp.ready = !q_full;
	assign acc       = smp.valid && smp.ready;
	assign is_zero   = smp.sample_mv <= margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
			offset_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MARGIN: margin_q <= cfg.data;
				REG_OFFSET: offset_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			if (smp.func == FUNC_START) begin
				phase_d = PH_WAIT;
			end else if (phase_q != PH_IDLE) begin
				if (is_zero) begin
					phase_d = (phase_q == PH_ABOVE) ? PH_IDLE : PH_BELOW;
				end else if (phase_q == PH_BELOW) begin
					phase_d = PH_ABOVE;
				end
			end
		end
	end

	// outputs
	always_comb begin
		q_ctl.push = 1'b0;
		track      = 1'b0;
		load_start = 1'b0;
		if (acc && smp.func == FUNC_SAMPLE && phase_q != PH_IDLE) begin
			if (is_zero) begin
				q_ctl.push = (phase_q == PH_ABOVE);
				load_start = (phase_q != PH_ABOVE);
			end else begin
				track = (phase_q == PH_BELOW) || (phase_q == PH_ABOVE);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			peak_q  <= '0;
			start_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (acc && smp.func == FUNC_START) begin
				peak_q  <= '0;
				start_q <= '0;
			end else begin
				if (track && peak_q < smp.sample_mv) begin
					peak_q <= smp.sample_mv;
				end
				if (load_start) begin
					start_q <= smp.time_us;
				end
			end
		end
	end

	// saturated level and half period
	assign sum = (SAMPLE_W+1)'(offset_q) + (SAMPLE_W+1)'(peak_q);

	always_comb begin
		if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
			job.level_mv = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
				: {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			job.level_mv = sum[SAMPLE_W-1:0];
		end
		job.half_period_us = smp.time_us - start_q;
	end

endmodule

// ===== src/zcpf_queue.sv =====
`timescale 1ns / 1ps
// short queue of measurements between front end and divider
module zcpf_queue #(
	parameter int DEPTH = zcpf_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  zcpf_pkg::queue_ctl_t q_ctl,
	input  zcpf_pkg::job_t       wr_job,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output zcpf_pkg::job_t       rd_job
);
	import zcpf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = q_ctl.push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

endmodule

// ===== src/zcpf_back.sv =====
`timescale 1ns / 1ps
// back end: radix-2 frequency divider and result register
module zcpf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	output logic           q_pop,
	input  zcpf_pkg::job_t q_job,
	zcpf_res_if.source     res
);
	import zcpf_pkg::*;

	div_state_t            st_q;
	div_state_t            st_d;
	job_t                  job_q;
	logic [TIME_W-1:0]     rem_q;
	logic [FREQ_W-1:0]     quot_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [TIME_W:0]       trial;
	logic [TIME_W:0]       diff;
	logic                  load;
	logic                  step;
	logic                  last;

	assign trial = {rem_q, quot_q[FREQ_W-1]};
	assign diff  = trial - {1'b0, job_q.half_period_us};
	assign last  = cnt_q == DIV_CNT_W'(1);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			DV_IDLE: begin
				if (!q_empty) begin
					st_d = (q_job.half_period_us == '0) ? DV_DONE : DV_RUN;
				end
			end
			DV_RUN: begin
				if (last) begin
					st_d = DV_DONE;
				end
			end
			DV_DONE: begin
				if (res.ready) begin
					st_d = DV_IDLE;
				end
			end
			default: st_d = DV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		load      = 1'b0;
		step      = 1'b0;
		res.valid = 1'b0;
		case (st_q)
			DV_IDLE: load = !q_empty;
			DV_RUN:  step = 1'b1;
			DV_DONE: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign q_pop              = load;
	assign res.level_mv       = job_q.level_mv;
	assign res.half_period_us = job_q.half_period_us;
	assign res.freq_hz        = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DV_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (load) begin
				cnt_q <= DIV_CNT_W'(FREQ_W);
			end else if (step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q  <= q_job;
			rem_q  <= '0;
			quot_q <= (q_job.half_period_us == '0) ? FREQ_MAX : HALF_MEGA;
		end else if (step) begin
			if (!diff[TIME_W]) begin
				rem_q  <= diff[TIME_W-1:0];
				quot_q <= {quot_q[FREQ_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[TIME_W-1:0];
				quot_q <= {quot_q[FREQ_W-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== src/zero_cross_peak_frequency_meter.sv =====
`timescale 1ns / 1ps
// top level of the zero cross peak frequency meter
// A start command (func = 1) clears the peak and arms the detector; samples then
// move it through waiting, below and above the margin, and the first sample back
// at or below the margin after the above phase yields one result: offset plus
// peak (saturated), the half period in microseconds and 500000 / half period in
// Hz (500000 when the half period is zero). Samples are taken one per cycle while
// the measurement queue has room. With the back end free, the result of a crossing
// sample passes through a queue pop, then 19 steps of the radix-2 divider, and
// stays in the result register until its transfer; the back end takes no new
// measurement before that transfer. A zero half period skips the divider.
module zero_cross_peak_frequency_meter #(
	parameter int QUEUE_DEPTH = zcpf_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	zcpf_smp_if.sink   smp,
	zcpf_cfg_if.sink   cfg,
	zcpf_res_if.source res
);
	import zcpf_pkg::*;

	queue_ctl_t q_ctl;
	job_t       wr_job;
	job_t       rd_job;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;

	zcpf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.cfg    (cfg),
		.q_full (q_full),
		.q_ctl  (q_ctl),
		.job    (wr_job)
	);

	zcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_ctl  (q_ctl),
		.wr_job (wr_job),
		.full   (q_full),
		.empty  (q_empty),
		.pop    (q_pop),
		.rd_job (rd_job)
	);

	zcpf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_job   (rd_job),
		.res     (res)
	);

endmodule

// ===== tb/zcpf_checker.sv =====
`timescale 1ns / 1ps
// checker of the zero cross peak frequency meter: predicts every reading and compares it
module zcpf_checker
	import zcpf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	zcpf_smp_if  smp,
	zcpf_cfg_if  cfg,
	zcpf_res_if  res,
	output int   fail_count,
	output int   outstanding
);

	localparam longint unsigned MEGA = 64'd1000000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level_mv;
		logic [TIME_W-1:0]          half_period_us;
		logic [FREQ_W-1:0]          freq_hz;
	} reading_t;

	logic signed [SAMPLE_W-1:0] margin;
	logic signed [SAMPLE_W-1:0] offset;
	logic signed [SAMPLE_W-1:0] peak;
	logic [TIME_W-1:0]          t_start;
	phase_t                     phase;
	reading_t                   reading_q[$];
	reading_t                   want;
	int                         fails = 0;

	task automatic track_sample(input logic f, input logic signed [SAMPLE_W-1:0] s,
			input logic [TIME_W-1:0] t);
		int lvl;
		logic [TIME_W-1:0] dt;
		reading_t r;
		if (f == FUNC_START) begin
			peak = '0;
			t_start = '0;
			phase = PH_WAIT;
		end else if (phase != PH_IDLE) begin
			if (s <= margin) begin
				if (phase == PH_ABOVE) begin
					dt = t - t_start;
					lvl = int'(offset) + int'(peak);
					if (lvl > 32767)
						lvl = 32767;
					if (lvl < -32768)
						lvl = -32768;
					r.level_mv = SAMPLE_W'(lvl);
					r.half_period_us = dt;
					r.freq_hz = (dt == '0) ? FREQ_MAX : FREQ_W'(MEGA / (64'(dt) * 64'd2));
					reading_q.push_back(r);
					phase = PH_IDLE;
				end else begin
					phase = PH_BELOW;
					t_start = t;
				end
			end else begin
				if (phase == PH_BELOW)
					phase = PH_ABOVE;
				if (phase == PH_ABOVE && peak < s)
					peak = s;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin = '0;
			offset = '0;
			peak = '0;
			t_start = '0;
			phase = PH_IDLE;
			reading_q.delete();
			outstanding <= 0;
			fail_count <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (reading_q.size() == 0) begin
					$error("unexpected result transfer: level_mv %0d half_period_us %0d freq_hz %0d",
						res.level_mv, res.half_period_us, res.freq_hz);
					fails++;
				end else begin
					want = reading_q.pop_front();
					if (res.level_mv !== want.level_mv) begin
						$error("level_mv: expected %0d, got %0d", want.level_mv, res.level_mv);
						fails++;
					end
					if (res.half_period_us !== want.half_period_us) begin
						$error("half_period_us: expected %0d, got %0d",
							want.half_period_us, res.half_period_us);
						fails++;
					end
					if (res.freq_hz !== want.freq_hz) begin
						$error("freq_hz: expected %0d, got %0d", want.freq_hz, res.freq_hz);
						fails++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MARGIN: margin = cfg.data;
					REG_OFFSET: offset = cfg.data;
					default: ;
				endcase
			end
			if (smp.valid && smp.ready)
				track_sample(smp.func, smp.sample_mv, smp.time_us);
			outstanding <= reading_q.size();
			fail_count <= fails;
		end
	end

endmodule

// ===== tb/zero_cross_peak_frequency_meter_tb.sv =====
`timescale 1ns / 1ps
// testbench top of the zero cross peak frequency meter: stimulus, flow control and verdict
module zero_cross_peak_frequency_meter_tb;
	import zcpf_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 600;
	localparam int SETTLE      = 25;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   calm = 1'b0;
	bit   hold_go = 1'b0;
	bit   tx_lazy = 1'b1;
	int   fails;
	int   outstanding;
	int   sent = 0;
	int   cur_margin = 0;
	int   idle_cycles = 0;

	zcpf_smp_if smp_ch ();
	zcpf_cfg_if cfg_ch ();
	zcpf_res_if res_ch ();

	zero_cross_peak_frequency_meter i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.smp   (smp_ch),
		.cfg   (cfg_ch),
		.res   (res_ch)
	);

	zcpf_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp        (smp_ch),
		.cfg        (cfg_ch),
		.res        (res_ch),
		.fail_count (fails),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("[zero_cross_peak_frequency_meter] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : result_side
		int gap;
		int quiet;
		bit held;
		gap = 0;
		quiet = 0;
		held = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				res_ch.ready <= 1'b0;
			end else if (hold_go && !held) begin
				held = 1'b1;
				gap = LONG_HOLD;
				res_ch.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				res_ch.ready <= 1'b0;
			end else if (calm || quiet > 0) begin
				if (quiet > 0)
					quiet--;
				res_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 29) == 0) begin
				quiet = $urandom_range(20, 80);
				res_ch.ready <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				gap = $urandom_range(0, 9);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int pick_between(input int lo, input int hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			default: return lo + int'($urandom_range(0, hi - lo));
		endcase
	endfunction

	function automatic logic [TIME_W-1:0] advance(input logic [TIME_W-1:0] t);
		case ($urandom_range(0, 9))
			0: return t;
			1: return t + 1;
			2, 3, 4, 5: return t + $urandom_range(2, 50);
			6, 7, 8: return t + $urandom_range(51, 100000);
			default: return t + $urandom();
		endcase
	endfunction

	task automatic put_item(input logic f, input int s, input logic [TIME_W-1:0] t);
		int gap;
		if (!calm && tx_lazy && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			smp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_ch.valid     <= 1'b1;
		smp_ch.func      <= f;
		smp_ch.sample_mv <= SAMPLE_W'(s);
		smp_ch.time_us   <= t;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		smp_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_levels(input int m, input int o);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_MARGIN;
		cfg_ch.data  <= CFG_DATA_W'(m);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.index <= REG_OFFSET;
		cfg_ch.data  <= CFG_DATA_W'(o);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		cur_margin = m;
	endtask

	task automatic play_swing();
		logic [TIME_W-1:0] t;
		tx_lazy = ($urandom_range(0, 3) != 0);
		t = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 6)) begin
				t = advance(t);
				put_item(($urandom_range(0, 5) == 0) ? FUNC_START : FUNC_SAMPLE,
					pick_between(-32768, 32767), t);
			end
			return;
		end
		put_item(FUNC_START, pick_between(-32768, 32767), t);
		if (cur_margin < 32767 && $urandom_range(0, 4) == 0) begin
			t = advance(t);
			put_item(FUNC_SAMPLE, pick_between(cur_margin + 1, 32767), t);
		end
		repeat ($urandom_range(1, 3)) begin
			t = advance(t);
			put_item(FUNC_SAMPLE, pick_between(-32768, cur_margin), t);
		end
		if (cur_margin == 32767)
			return;
		repeat ($urandom_range(1, 4)) begin
			t = advance(t);
			put_item(FUNC_SAMPLE, pick_between(cur_margin + 1, 32767), t);
			if ($urandom_range(0, 24) == 0)
				put_item(FUNC_START, pick_between(-32768, 32767), t);
		end
		if ($urandom_range(0, 9) != 0) begin
			t = advance(t);
			put_item(FUNC_SAMPLE, pick_between(-32768, cur_margin), t);
		end
	endtask

	initial begin : stimulus
		int margins[6];
		int offsets[6];
		int quotas[6];
		bit drained_once;
		drained_once = 1'b0;
		smp_ch.valid = 1'b0;
		smp_ch.func = FUNC_SAMPLE;
		smp_ch.sample_mv = '0;
		smp_ch.time_us = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_MARGIN;
		cfg_ch.data = '0;
		margins = '{0, -32768, pick_between(-20000, 20000), 32767,
			pick_between(-20000, 20000), pick_between(-2000, 2000)};
		offsets = '{0, 32767, pick_between(-32768, 32767), -32768,
			pick_between(-32768, 32767), pick_between(-32768, 32767)};
		quotas = '{200, 150, 200, 60, 200, 200};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_levels(0, 0);

		// idle and waiting states ignore samples
		put_item(FUNC_SAMPLE, 100, 32'd5);
		put_item(FUNC_START, 0, 32'd6);
		put_item(FUNC_SAMPLE, 32767, 32'd7);
		// crossing across the timestamp wrap, margin is inclusive
		put_item(FUNC_SAMPLE, 0, 32'hFFFF_FFF0);
		put_item(FUNC_SAMPLE, 1, 32'hFFFF_FFF8);
		put_item(FUNC_SAMPLE, 32767, 32'hFFFF_FFFC);
		put_item(FUNC_SAMPLE, -32768, 32'h0000_000E);
		// zero half period
		put_item(FUNC_START, -1, 32'hFFFF_FFFF);
		put_item(FUNC_SAMPLE, -7, 32'd1234);
		put_item(FUNC_SAMPLE, 9, 32'd1234);
		put_item(FUNC_SAMPLE, 0, 32'd1234);
		// restart while above, then the longest half period
		put_item(FUNC_START, 0, 32'd0);
		put_item(FUNC_SAMPLE, -1, 32'd0);
		put_item(FUNC_SAMPLE, 200, 32'd3);
		put_item(FUNC_START, 0, 32'd4);
		put_item(FUNC_SAMPLE, -300, 32'd0);
		put_item(FUNC_SAMPLE, 300, 32'd1);
		put_item(FUNC_SAMPLE, -32768, 32'hFFFF_FFFF);
		// level saturates high
		set_levels(-32768, 32767);
		put_item(FUNC_START, 32767, 32'd99);
		put_item(FUNC_SAMPLE, -32768, 32'd100);
		put_item(FUNC_SAMPLE, 32767, 32'd200);
		put_item(FUNC_SAMPLE, -32768, 32'd201);
		// negative swing keeps the cleared peak, half period of one
		set_levels(-1000, -32768);
		put_item(FUNC_START, 0, 32'd9);
		put_item(FUNC_SAMPLE, -2000, 32'd10);
		put_item(FUNC_SAMPLE, -1, 32'd11);
		put_item(FUNC_SAMPLE, -1000, 32'd11);

		for (int p = 0; p < 6; p++) begin
			set_levels(margins[p], offsets[p]);
			if (p == 2)
				hold_go <= 1'b1;
			sent = 0;
			while (sent < quotas[p]) begin
				play_swing();
				if (p == 4 && !drained_once && sent > quotas[p] / 2) begin
					drain();
					drained_once = 1'b1;
				end
				if (p == 5 && sent > quotas[p] / 2)
					calm = 1'b1;
			end
		end

		drain();
		if (fails == 0 && outstanding == 0)
			$display("[zero_cross_peak_frequency_meter] OK");
		else
			$display("[zero_cross_peak_frequency_meter] ERROR");
		$finish;
	end

endmodule

// ===== zero_cross_peak_frequency_meter.f =====
src/zcpf_pkg.sv
src/zcpf_if.sv
src/zcpf_front.sv
src/zcpf_queue.sv
src/zcpf_back.sv
src/zero_cross_peak_frequency_meter.sv
tb/zcpf_checker.sv
tb/zero_cross_peak_frequency_meter_tb.sv
